### design/bsmm_pkg.sv
// Shared types and constants for the bounded min/max stack.
package bsmm_pkg;

    // Number of cells in the stack row
    localparam int DEPTH = 1024;
    // Width of the held-entry counter, able to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Fixed field widths
    localparam int VAL_W = 32;
    localparam int CAP_W = 11;
    localparam int OUT_CNT_W = 11;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Prefix minimum and maximum held next to one entry
    typedef struct packed {
        logic signed [VAL_W-1:0] pmin;
        logic signed [VAL_W-1:0] pmax;
    } t_pair;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

### design/bsmm_if.sv
// Handshake channel interfaces for commands, results and configuration.
interface bsmm_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [bsmm_pkg::VAL_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bsmm_res_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic [bsmm_pkg::OUT_CNT_W-1:0]         count;
    logic                                   is_empty;
    logic                                   is_full;
    logic signed [bsmm_pkg::VAL_W-1:0]      min_value;
    logic signed [bsmm_pkg::VAL_W-1:0]      max_value;

    modport source (output valid, output status, output count, output is_empty,
                    output is_full, output min_value, output max_value, input ready);
    modport sink   (input valid, input status, input count, input is_empty,
                    input is_full, input min_value, input max_value, output ready);
endinterface

interface bsmm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bsmm_pkg::CAP_W-1:0]     capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

### design/bounded_stack_min_max.sv
// Top level of the bounded min/max stack: control, result register and cell row.
// Each accepted command beat gets a registered result beat in the following cycle.
// Throughput: one command per cycle while the sink takes each result; on an accepted
// push or pop every cell shifts by one place, and the result register frees as soon as the sink takes its beat.
// Reset (i_rst_n low, synchronous): count and capacity clear to zero, the
// result register empties; cell contents stay undefined and need no clearing.
module bounded_stack_min_max (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsmm_cmd_if.sink        i_cmd,
    bsmm_cfg_if.sink        i_cfg,
    bsmm_res_if.source      o_res
);
    import bsmm_pkg::*;

    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_full;
    logic               n_out_full;
    t_pair              r_out_pair;
    t_pair              n_out_pair;

    t_pair              cell_pair [DEPTH];
    t_pair              push_pair;
    t_pair              top_pair;
    t_shift             shift;
    logic               accept;
    logic [31:0]        eff_cap;
    logic [31:0]        count32;
    logic [31:0]        n_count32;

    // Configuration is always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.capacity;
        end
    end

    // Accept while the result register is free or draining
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Saturate capacity at the row length
    assign count32 = 32'(r_count);
    assign eff_cap = (32'(r_cap) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_cap);

    // New top pair for a push: fold the value into the current top
    always_comb begin
        push_pair.pmin = i_cmd.value;
        push_pair.pmax = i_cmd.value;
        if (r_count != '0) begin
            if (cell_pair[0].pmin < i_cmd.value) begin
                push_pair.pmin = cell_pair[0].pmin;
            end
            if (cell_pair[0].pmax > i_cmd.value) begin
                push_pair.pmax = cell_pair[0].pmax;
            end
        end
    end

    // Decide the operation and the resulting count and top
    always_comb begin
        shift    = '0;
        n_count  = r_count;
        n_status = ST_DONE;
        top_pair = cell_pair[0];
        if (i_cmd.command == CMD_PUSH) begin
            if (count32 >= eff_cap) begin
                n_status = ST_FULL;
            end else begin
                shift.push = accept;
                n_count    = r_count + 1'b1;
                top_pair   = push_pair;
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                shift.pop = accept;
                n_count   = r_count - 1'b1;
                top_pair  = cell_pair[1];
            end
        end
    end

    // Result fields; an empty stack reports zero min and max
    assign n_count32 = 32'(n_count);
    always_comb begin
        n_out_full = n_count32 >= eff_cap;
        n_out_pair = top_pair;
        if (n_count == '0) begin
            n_out_pair = '0;
        end
    end

    // Control state: count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_count <= n_count;
            r_out_full  <= n_out_full;
            r_out_pair  <= n_out_pair;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_status;
    assign o_res.count     = OUT_CNT_W'(r_out_count);
    assign o_res.is_empty  = (r_out_count == '0);
    assign o_res.is_full   = r_out_full;
    assign o_res.min_value = r_out_pair.pmin;
    assign o_res.max_value = r_out_pair.pmax;

    // Row of cells, top of stack at cell 0
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_pair from_up;
        t_pair from_down;
        if (k == 0) begin : g_top
            assign from_up = push_pair;
        end else begin : g_mid
            assign from_up = cell_pair[k-1];
        end
        if (k == DEPTH - 1) begin : g_bot
            assign from_down = cell_pair[k];
        end else begin : g_inner
            assign from_down = cell_pair[k+1];
        end
        bsmm_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (shift),
            .i_from_up   (from_up),
            .i_from_down (from_down),
            .o_pair      (cell_pair[k])
        );
    end

    // Count never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("count exceeds depth");

    // A rejected command leaves the count unchanged
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_status != ST_DONE) |=> $stable(r_count))
        else $error("rejected command changed count");

    // A good push grows the count by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && shift.push) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow count");

    // An empty result reports zero min and max
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty) |-> (o_res.min_value == 0 && o_res.max_value == 0))
        else $error("empty result with nonzero min/max");

    // A full rejection result also raises the full flag
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_FULL) |-> o_res.is_full)
        else $error("full rejection without full flag");

endmodule

### design/bsmm_cell.sv
// One stack cell: holds a prefix min/max pair and shifts with its neighbors.
module bsmm_cell (
    input  logic            i_clk,
    input  bsmm_pkg::t_shift i_shift,
    input  bsmm_pkg::t_pair i_from_up,
    input  bsmm_pkg::t_pair i_from_down,
    output bsmm_pkg::t_pair o_pair
);
    import bsmm_pkg::*;

    t_pair r_pair;
    t_pair n_pair;

    // Take the upper neighbor on push, the lower one on pop, else hold
    always_comb begin
        n_pair = r_pair;
        if (i_shift.push) begin
            n_pair = i_from_up;
        end else if (i_shift.pop) begin
            n_pair = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

    assign o_pair = r_pair;

endmodule
